@@ src/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and control types for the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int HSV_FRAC_BITS = 12;
    localparam int IN_W          = 13;
    localparam int HUE_SECTOR    = 960;
    localparam int HUE_SHIFT     = 6;
    localparam int HUE_ODD       = 15;
    localparam int SEC_W         = 4;
    localparam int REM_W         = 10;
    localparam int PIPE_DEPTH    = 6;

    localparam logic [SEC_W-1:0] SEC_RED_YELLOW   = 4'd0;
    localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN = 4'd1;
    localparam logic [SEC_W-1:0] SEC_GREEN_CYAN   = 4'd2;
    localparam logic [SEC_W-1:0] SEC_CYAN_BLUE    = 4'd3;
    localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA = 4'd4;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } t_ld2;

endpackage

@@ src/hsv2rgb_sector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Clamps saturation and value to 1.0 and splits the hue into its 60-degree
// sector and the remainder within it.
// ----------------------------------------------------------------------------
module hsv2rgb_sector import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = HSV_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [IN_W-1:0]      i_hue,
    input  logic [IN_W-1:0]      i_saturation,
    input  logic [IN_W-1:0]      i_value,
    output logic [FRAC_BITS:0]   o_s,
    output logic [FRAC_BITS:0]   o_v,
    output logic [SEC_W-1:0]     o_sec,
    output logic [REM_W-1:0]     o_rem
);

    localparam int W  = FRAC_BITS + 1;
    localparam int CW = (IN_W > W) ? IN_W : W;
    localparam logic [CW-1:0] ONE_C = CW'(1 << FRAC_BITS);

    logic [CW-1:0]    s_ext;
    logic [CW-1:0]    v_ext;
    logic [W-1:0]     n_s;
    logic [W-1:0]     n_v;
    logic [IN_W-1:0]  rem_w;
    logic [SEC_W-1:0] n_sec;
    logic [REM_W-1:0] n_rem;

    logic [W-1:0]     r_s;
    logic [W-1:0]     r_v;
    logic [SEC_W-1:0] r_sec;
    logic [REM_W-1:0] r_rem;

    always_comb begin
        s_ext = CW'(i_saturation);
        v_ext = CW'(i_value);
        n_s   = (s_ext > ONE_C) ? W'(ONE_C) : W'(s_ext);
        n_v   = (v_ext > ONE_C) ? W'(ONE_C) : W'(v_ext);
    end

    // restoring split by 960, one sector bit per step
    always_comb begin
        rem_w = i_hue;
        n_sec = '0;
        for (int i = SEC_W - 1; i >= 0; i--) begin
            if (rem_w >= IN_W'(HUE_SECTOR << i)) begin
                rem_w    = rem_w - IN_W'(HUE_SECTOR << i);
                n_sec[i] = 1'b1;
            end
        end
        n_rem = rem_w[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s   <= n_s;
            r_v   <= n_v;
            r_sec <= n_sec;
            r_rem <= n_rem;
        end
    end

    assign o_s   = r_s;
    assign o_v   = r_v;
    assign o_sec = r_sec;
    assign o_rem = r_rem;

endmodule

@@ src/hsv2rgb_frac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_frac
// Two-stage fraction unit: f = floor(rem * ONE / 960) by reciprocal
// multiplication followed by a single correction step.
// ----------------------------------------------------------------------------
module hsv2rgb_frac import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = HSV_FRAC_BITS
) (
    input  logic                 i_clk,
    input  t_ld2                 i_ld,
    input  logic [FRAC_BITS:0]   i_s,
    input  logic [FRAC_BITS:0]   i_v,
    input  logic [SEC_W-1:0]     i_sec,
    input  logic [REM_W-1:0]     i_rem,
    output logic [FRAC_BITS:0]   o_s,
    output logic [FRAC_BITS:0]   o_v,
    output logic [SEC_W-1:0]     o_sec,
    output logic [FRAC_BITS-1:0] o_f
);

    localparam int W  = FRAC_BITS + 1;
    localparam int XW = REM_W + FRAC_BITS - HUE_SHIFT;
    localparam int RW = FRAC_BITS + 1;
    localparam int PW = XW + RW;
    localparam logic [RW-1:0] RECIP = RW'((1 << XW) / HUE_ODD);

    logic [XW-1:0]        n_x;
    logic [PW-1:0]        n_prod;
    logic [FRAC_BITS-1:0] n_q0;
    logic [XW-1:0]        back;
    logic [XW-1:0]        resid;
    logic [FRAC_BITS-1:0] n_f;

    logic [XW-1:0]        r_x;
    logic [FRAC_BITS-1:0] r_q0;
    logic [W-1:0]         r_s_a;
    logic [W-1:0]         r_v_a;
    logic [SEC_W-1:0]     r_sec_a;
    logic [FRAC_BITS-1:0] r_f;
    logic [W-1:0]         r_s_b;
    logic [W-1:0]         r_v_b;
    logic [SEC_W-1:0]     r_sec_b;

    always_comb begin
        n_x    = XW'(i_rem) << (FRAC_BITS - HUE_SHIFT);
        n_prod = PW'(n_x) * PW'(RECIP);
        n_q0   = n_prod[XW +: FRAC_BITS];
    end

    // estimate is low by at most one
    always_comb begin
        back  = XW'(r_q0) * XW'(HUE_ODD);
        resid = r_x - back;
        n_f   = (resid >= XW'(HUE_ODD)) ? r_q0 + FRAC_BITS'(1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_a) begin
            r_x     <= n_x;
            r_q0    <= n_q0;
            r_s_a   <= i_s;
            r_v_a   <= i_v;
            r_sec_a <= i_sec;
        end
        if (i_ld.ld_b) begin
            r_f     <= n_f;
            r_s_b   <= r_s_a;
            r_v_b   <= r_v_a;
            r_sec_b <= r_sec_a;
        end
    end

    assign o_s   = r_s_b;
    assign o_v   = r_v_b;
    assign o_sec = r_sec_b;
    assign o_f   = r_f;

endmodule

@@ src/hsv2rgb_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_mul
// Two product rows: s*f, s*(1-f) and p = v*(1-s), then q and t from v.
// Every product is truncated to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module hsv2rgb_mul import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = HSV_FRAC_BITS
) (
    input  logic                 i_clk,
    input  t_ld2                 i_ld,
    input  logic [FRAC_BITS:0]   i_s,
    input  logic [FRAC_BITS:0]   i_v,
    input  logic [SEC_W-1:0]     i_sec,
    input  logic [FRAC_BITS-1:0] i_f,
    output logic [FRAC_BITS:0]   o_p,
    output logic [FRAC_BITS:0]   o_q,
    output logic [FRAC_BITS:0]   o_t,
    output logic [FRAC_BITS:0]   o_v,
    output logic [SEC_W-1:0]     o_sec
);

    localparam int W  = FRAC_BITS + 1;
    localparam int PW = 2 * W;
    localparam logic [W-1:0] ONE_W = W'(1 << FRAC_BITS);

    logic [PW-1:0]    sf_prod;
    logic [PW-1:0]    s1f_prod;
    logic [PW-1:0]    p_prod;
    logic [PW-1:0]    q_prod;
    logic [PW-1:0]    t_prod;

    logic [W-1:0]     r_sf;
    logic [W-1:0]     r_s1f;
    logic [W-1:0]     r_p_a;
    logic [W-1:0]     r_v_a;
    logic [SEC_W-1:0] r_sec_a;
    logic [W-1:0]     r_p_b;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_t;
    logic [W-1:0]     r_v_b;
    logic [SEC_W-1:0] r_sec_b;

    always_comb begin
        sf_prod  = PW'(i_s) * PW'(i_f);
        s1f_prod = PW'(i_s) * PW'(ONE_W - W'(i_f));
        p_prod   = PW'(i_v) * PW'(ONE_W - i_s);
        q_prod   = PW'(r_v_a) * PW'(ONE_W - r_sf);
        t_prod   = PW'(r_v_a) * PW'(ONE_W - r_s1f);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_a) begin
            r_sf    <= sf_prod[FRAC_BITS +: W];
            r_s1f   <= s1f_prod[FRAC_BITS +: W];
            r_p_a   <= p_prod[FRAC_BITS +: W];
            r_v_a   <= i_v;
            r_sec_a <= i_sec;
        end
        if (i_ld.ld_b) begin
            r_q     <= q_prod[FRAC_BITS +: W];
            r_t     <= t_prod[FRAC_BITS +: W];
            r_p_b   <= r_p_a;
            r_v_b   <= r_v_a;
            r_sec_b <= r_sec_a;
        end
    end

    assign o_p   = r_p_b;
    assign o_q   = r_q;
    assign o_t   = r_t;
    assign o_v   = r_v_b;
    assign o_sec = r_sec_b;

endmodule

@@ src/hsv_to_rgb_convert_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_top
// HSV to RGB colour converter, fixed point, one colour per clock when not stalled.
// ----------------------------------------------------------------------------
// Takes one request per clock while o_stall is low; results leave in order. The
// six register stages are: clamp and hue sector split, reciprocal multiply
// for the sector fraction, fraction correction, first product row (s*f,
// s*(1-f), p), second product row (q, t) and the sector select into the
// output register. Each stage holds only while the stage after it is full
// and held, so empty stages close up and a stalled output does not block
// input until the whole pipe is full. Zero saturation gives grey.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_top import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = HSV_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [IN_W-1:0] i_hue,
    input  logic [IN_W-1:0] i_saturation,
    input  logic [IN_W-1:0] i_value,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [IN_W-1:0] o_red,
    output logic [IN_W-1:0] o_green,
    output logic [IN_W-1:0] o_blue
);

    localparam int W = FRAC_BITS + 1;

    logic [PIPE_DEPTH:0]   rdy;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH-1:0] r_vld;

    t_ld2 ld_frac;
    t_ld2 ld_mul;

    logic [W-1:0]         s_sec;
    logic [W-1:0]         v_sec;
    logic [SEC_W-1:0]     sec_sec;
    logic [REM_W-1:0]     rem_sec;
    logic [W-1:0]         s_frac;
    logic [W-1:0]         v_frac;
    logic [SEC_W-1:0]     sec_frac;
    logic [FRAC_BITS-1:0] f_frac;
    logic [W-1:0]         p_mul;
    logic [W-1:0]         q_mul;
    logic [W-1:0]         t_mul;
    logic [W-1:0]         v_mul;
    logic [SEC_W-1:0]     sec_mul;

    logic [W-1:0]    sel_r;
    logic [W-1:0]    sel_g;
    logic [W-1:0]    sel_b;
    logic [IN_W-1:0] r_red;
    logic [IN_W-1:0] r_green;
    logic [IN_W-1:0] r_blue;

    always_comb begin
        rdy[PIPE_DEPTH] = !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign ld_frac = '{ld_a: rdy[1], ld_b: rdy[2]};
    assign ld_mul  = '{ld_a: rdy[3], ld_b: rdy[4]};

    hsv2rgb_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
        .i_clk        (i_clk),
        .i_load       (rdy[0]),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_value      (i_value),
        .o_s          (s_sec),
        .o_v          (v_sec),
        .o_sec        (sec_sec),
        .o_rem        (rem_sec)
    );

    hsv2rgb_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
        .i_clk (i_clk),
        .i_ld  (ld_frac),
        .i_s   (s_sec),
        .i_v   (v_sec),
        .i_sec (sec_sec),
        .i_rem (rem_sec),
        .o_s   (s_frac),
        .o_v   (v_frac),
        .o_sec (sec_frac),
        .o_f   (f_frac)
    );

    hsv2rgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_ld  (ld_mul),
        .i_s   (s_frac),
        .i_v   (v_frac),
        .i_sec (sec_frac),
        .i_f   (f_frac),
        .o_p   (p_mul),
        .o_q   (q_mul),
        .o_t   (t_mul),
        .o_v   (v_mul),
        .o_sec (sec_mul)
    );

    always_comb begin
        unique case (sec_mul)
            SEC_RED_YELLOW: begin
                sel_r = v_mul; sel_g = t_mul; sel_b = p_mul;
            end
            SEC_YELLOW_GREEN: begin
                sel_r = q_mul; sel_g = v_mul; sel_b = p_mul;
            end
            SEC_GREEN_CYAN: begin
                sel_r = p_mul; sel_g = v_mul; sel_b = t_mul;
            end
            SEC_CYAN_BLUE: begin
                sel_r = p_mul; sel_g = q_mul; sel_b = v_mul;
            end
            SEC_BLUE_MAGENTA: begin
                sel_r = t_mul; sel_g = p_mul; sel_b = v_mul;
            end
            default: begin
                sel_r = v_mul; sel_g = p_mul; sel_b = q_mul;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[PIPE_DEPTH-1]) begin
            r_red   <= IN_W'(sel_r);
            r_green <= IN_W'(sel_g);
            r_blue  <= IN_W'(sel_b);
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ src/hsv2rgb_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_chk
// Port-level checks on the colour converter: output hold, back-pressure
// origin and pipeline latency.
// ----------------------------------------------------------------------------
module hsv2rgb_chk import hsv2rgb_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [IN_W-1:0] o_red,
    input logic [IN_W-1:0] o_green,
    input logic [IN_W-1:0] o_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue))
        else $error("result changed while held");

    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input held without a held result");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
            ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("request did not reach the output in six cycles");

endmodule

bind hsv_to_rgb_convert_top hsv2rgb_chk u_hsv2rgb_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
// Drives colour requests through the valid/stall handshake, with random
// gaps on the request side and random stalls on the result side. A
// scoreboard object works out the expected RGB triple for every accepted
// request and compares each returned colour field by field, in order.
// Directed corners come first: sector edges, hue beyond 360 degrees, grey,
// clamped saturation and value. Random colours follow.
// ----------------------------------------------------------------------------
module testbench import hsv2rgb_pkg::*;;

    localparam int NUM_RANDOM  = 1530;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [IN_W-1:0] t_field;

    typedef struct packed {
        t_field red;
        t_field green;
        t_field blue;
    } t_rgb;

    class colour_scoreboard;
        t_rgb expected_colours[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function t_rgb predict_colour(t_field hue, t_field sat, t_field val);
            longint unsigned one, s, v, sector, rem, f, p, q, t;
            t_rgb c;
            one = longint'(1) << HSV_FRAC_BITS;
            s = (sat > one) ? one : longint'(sat);
            v = (val > one) ? one : longint'(val);
            sector = hue / HUE_SECTOR;
            rem = hue % HUE_SECTOR;
            f = (rem << HSV_FRAC_BITS) / HUE_SECTOR;
            if (s == 0) begin
                c.red   = t_field'(v);
                c.green = t_field'(v);
                c.blue  = t_field'(v);
                return c;
            end
            p = (v * (one - s)) >> HSV_FRAC_BITS;
            q = (v * (one - ((s * f) >> HSV_FRAC_BITS))) >> HSV_FRAC_BITS;
            t = (v * (one - ((s * (one - f)) >> HSV_FRAC_BITS))) >> HSV_FRAC_BITS;
            case (sector)
                SEC_RED_YELLOW: begin
                    c.red = t_field'(v); c.green = t_field'(t); c.blue = t_field'(p);
                end
                SEC_YELLOW_GREEN: begin
                    c.red = t_field'(q); c.green = t_field'(v); c.blue = t_field'(p);
                end
                SEC_GREEN_CYAN: begin
                    c.red = t_field'(p); c.green = t_field'(v); c.blue = t_field'(t);
                end
                SEC_CYAN_BLUE: begin
                    c.red = t_field'(p); c.green = t_field'(q); c.blue = t_field'(v);
                end
                SEC_BLUE_MAGENTA: begin
                    c.red = t_field'(t); c.green = t_field'(p); c.blue = t_field'(v);
                end
                default: begin
                    c.red = t_field'(v); c.green = t_field'(p); c.blue = t_field'(q);
                end
            endcase
            return c;
        endfunction

        function void note_request(t_field hue, t_field sat, t_field val);
            expected_colours.insert(expected_colours.size(),
                                    predict_colour(hue, sat, val));
        endfunction

        function int pending();
            return expected_colours.size();
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_colour(t_field red, t_field green, t_field blue);
            t_rgb exp_c;
            if (expected_colours.size() == 0) begin
                report($sformatf("colour %0d/%0d/%0d with no request waiting",
                                 red, green, blue));
                return;
            end
            exp_c = expected_colours.pop_front();
            if (red !== exp_c.red)
                report($sformatf("red %0d, expected %0d", red, exp_c.red));
            if (green !== exp_c.green)
                report($sformatf("green %0d, expected %0d", green, exp_c.green));
            if (blue !== exp_c.blue)
                report($sformatf("blue %0d, expected %0d", blue, exp_c.blue));
        endtask
    endclass

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    logic   i_stall      = 1'b0;
    t_field i_hue        = '0;
    t_field i_saturation = '0;
    t_field i_value      = '0;
    logic   o_stall;
    logic   o_valid;
    t_field o_red;
    t_field o_green;
    t_field o_blue;

    colour_scoreboard sb = new();
    bit quiet = 1'b0;
    int cycle_count = 0;

    hsv_to_rgb_convert_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_request(i_hue, i_saturation, i_value);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_colour(o_red, o_green, o_blue);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_field pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return t_field'(1 << HSV_FRAC_BITS);
            2: return t_field'($urandom_range(1, 15));
            3: return t_field'($urandom_range(4080, 4096));
            default: return t_field'($urandom_range(0, 1 << HSV_FRAC_BITS));
        endcase
    endfunction

    function automatic t_field pick_hue();
        int edge_sel;
        edge_sel = $urandom_range(0, 5);
        case ($urandom_range(0, 5))
            0: return t_field'(edge_sel * HUE_SECTOR);
            1: return t_field'(edge_sel * HUE_SECTOR + HUE_SECTOR - 1);
            default: return t_field'($urandom_range(0, 6 * HUE_SECTOR - 1));
        endcase
    endfunction

    task automatic send_request(input t_field hue, input t_field sat, input t_field val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid      <= 1'b0;
            i_hue        <= t_field'($urandom);
            i_saturation <= t_field'($urandom);
            i_value      <= t_field'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_value      <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_colours();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        int i;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sector edges at full saturation
        send_request(13'd0,    13'd4096, 13'd4096);
        send_request(13'd959,  13'd4096, 13'd4096);
        send_request(13'd960,  13'd4096, 13'd4096);
        send_request(13'd1919, 13'd4096, 13'd4096);
        send_request(13'd1920, 13'd4096, 13'd4096);
        send_request(13'd2879, 13'd4096, 13'd4096);
        send_request(13'd2880, 13'd4096, 13'd4096);
        send_request(13'd3840, 13'd4096, 13'd4096);
        send_request(13'd4800, 13'd4096, 13'd4096);
        send_request(13'd5759, 13'd4096, 13'd4096);
        // hue at and past 360 degrees
        send_request(13'd5760, 13'd3000, 13'd4000);
        send_request(13'd7000, 13'd2500, 13'd2500);
        send_request(13'd8191, 13'd8191, 13'd8191);
        // grey
        send_request(13'd480,  13'd0,    13'd3000);
        send_request(13'd2000, 13'd0,    13'd8191);
        send_request(13'd8191, 13'd0,    13'd0);
        // clamped saturation and value, tiny values
        send_request(13'd3000, 13'd4097, 13'd4096);
        send_request(13'd4321, 13'd2048, 13'd6000);
        send_request(13'd100,  13'd2048, 13'd0);
        send_request(13'd4000, 13'd1,    13'd4096);
        send_request(13'd1234, 13'd4096, 13'd1);
        send_request(13'd2500, 13'd4095, 13'd4095);

        i_valid <= 1'b0;
        @(posedge i_clk);
        drain_colours();

        for (i = 0; i < NUM_RANDOM; i++) begin
            quiet = (i % 300) < 60;
            if (i == NUM_RANDOM / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                drain_colours();
            end
            if ($urandom_range(0, 4) == 0)
                send_request(t_field'($urandom), t_field'($urandom), t_field'($urandom));
            else
                send_request(pick_hue(), pick_level(), pick_level());
        end
        quiet = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        drain_colours();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ files.f @@
src/hsv2rgb_pkg.sv
src/hsv2rgb_sector.sv
src/hsv2rgb_frac.sv
src/hsv2rgb_mul.sv
src/hsv_to_rgb_convert_top.sv
src/hsv2rgb_chk.sv
tb/testbench.sv
